@@ rtl/plsi_pkg.sv @@
// Shared types, widths, op codes and scale constants for the PMBus
// linear decode unit. No dependencies.
`timescale 1ns / 1ps

package plsi_pkg;

  localparam int OP_W    = 3;
  localparam int WORD_W  = 16;
  localparam int MODE_W  = 8;
  localparam int VALUE_W = 48;
  localparam int EXP_W   = 5;
  localparam int MANT_W  = 17;
  localparam int SCALE_W = 20;
  localparam int PROD_W  = MANT_W + SCALE_W + 1;
  localparam int L11_MANT_W = 11;

  localparam logic [SCALE_W-1:0] SCALE_NONE  = SCALE_W'(0);
  localparam logic [SCALE_W-1:0] SCALE_UNIT  = SCALE_W'(1);
  localparam logic [SCALE_W-1:0] SCALE_MILLI = SCALE_W'(1000);
  localparam logic [SCALE_W-1:0] SCALE_MICRO = SCALE_W'(1000000);

  typedef enum logic [OP_W-1:0] {
    OP_VOUT_U    = 3'd0,
    OP_VOUT_S    = 3'd1,
    OP_L11_MILLI = 3'd2,
    OP_L11_MICRO = 3'd3,
    OP_L11_UNIT  = 3'd4
  } op_t;

  // Decoded word, held between decode and multiply
  typedef struct packed {
    logic signed [MANT_W-1:0] mant;
    logic [SCALE_W-1:0]       scale;
    logic signed [EXP_W-1:0]  exp;
    logic                     nonlin;
  } dec_t;

  // Scaled mantissa, held between multiply and exponent shift
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic signed [EXP_W-1:0]  exp;
    logic                     nonlin;
  } mul_t;

endpackage

@@ rtl/plsi_word_if.sv @@
// Input channel: one PMBus data word with its format selector and VOUT_MODE.
// Depends on plsi_pkg.
`timescale 1ns / 1ps

interface plsi_word_if;
  logic                         valid;
  logic                         ready;
  logic [plsi_pkg::OP_W-1:0]    op;
  logic [plsi_pkg::WORD_W-1:0]  raw_word;
  logic [plsi_pkg::MODE_W-1:0]  mode_byte;

  modport source (output valid, op, raw_word, mode_byte, input ready);
  modport sink   (input valid, op, raw_word, mode_byte, output ready);
endinterface

@@ rtl/plsi_result_if.sv @@
// Output channel: one decoded scaled value and the non-linear mode flag.
// Depends on plsi_pkg.
`timescale 1ns / 1ps

interface plsi_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [plsi_pkg::VALUE_W-1:0] scaled_value;
  logic                                non_linear_mode;

  modport source (output valid, scaled_value, non_linear_mode, input ready);
  modport sink   (input valid, scaled_value, non_linear_mode, output ready);
endinterface

@@ rtl/plsi_exp_shift.sv @@
// Applies the signed exponent to a scaled mantissa: left shift, or
// divide by a power of two truncating toward zero. Depends on plsi_pkg.
`timescale 1ns / 1ps

module plsi_exp_shift (
  input  logic signed [plsi_pkg::PROD_W-1:0]  prod,
  input  logic signed [plsi_pkg::EXP_W-1:0]   exp,
  output logic signed [plsi_pkg::VALUE_W-1:0] value
);
  import plsi_pkg::*;

  logic signed [VALUE_W-1:0] wide;
  logic [EXP_W-1:0]          rshift;
  logic [VALUE_W-1:0]        mask;
  logic signed [VALUE_W-1:0] biased;

  // Sign-extend and form the right-shift distance for a negative exponent
  assign wide   = VALUE_W'(prod);
  assign rshift = ~exp + EXP_W'(1);
  assign mask   = (VALUE_W'(1) << rshift) - VALUE_W'(1);

  // Bias negative values so the arithmetic shift rounds toward zero
  assign biased = wide + (prod[PROD_W-1] ? $signed(mask) : $signed(VALUE_W'(0)));

  always_comb begin
    if (exp[EXP_W-1]) begin
      value = biased >>> rshift;
    end else begin
      value = wide <<< exp[EXP_W-2:0];
    end
  end

endmodule

@@ rtl/pmbus_linear_to_scaled_int_unit.sv @@
// Top level: three-stage PMBus LINEAR16 / LINEAR11 decoder.
// Depends on plsi_pkg, plsi_word_if, plsi_result_if and plsi_exp_shift.
//
//   channel | dir | payload
//   --------+-----+--------------------------------------------
//   word    | in  | op[2:0], raw_word[15:0], mode_byte[7:0]
//   result  | out | scaled_value[47:0] signed, non_linear_mode
//
// One beat per cycle while result is ready; the stages are decode, constant
// multiply and exponent shift, with the shift feeding the output register.
// Reset empties all three stages; payload registers are not cleared.
// A stall on result holds the output register; earlier stages keep filling
// bubbles, and word.ready drops only once every stage holds a beat.
`timescale 1ns / 1ps

module pmbus_linear_to_scaled_int_unit (
  input logic          clk,
  input logic          rst,
  plsi_word_if.sink    word,
  plsi_result_if.source result
);
  import plsi_pkg::*;

  logic v1, v2, v3;
  logic take1, take2, take3;
  dec_t dec_next, st1;
  mul_t st2;
  logic signed [VALUE_W-1:0] shifted;
  logic signed [VALUE_W-1:0] value;
  logic                      nonlin;

  // Advance a stage when the one after it is empty or moving
  assign take3 = !v3 || result.ready;
  assign take2 = !v2 || take3;
  assign take1 = !v1 || take2;
  assign word.ready = take1;

  // Decode the word into mantissa, scale and exponent
  always_comb begin
    dec_next = '0;
    unique case (word.op)
      OP_VOUT_U, OP_VOUT_S: begin
        dec_next.nonlin = |word.mode_byte[MODE_W-1:EXP_W];
        dec_next.exp    = dec_next.nonlin ? EXP_W'(0) : word.mode_byte[EXP_W-1:0];
        dec_next.scale  = SCALE_MILLI;
        if (word.op == OP_VOUT_U) begin
          dec_next.mant = {1'b0, word.raw_word};
        end else begin
          dec_next.mant = {word.raw_word[WORD_W-1], word.raw_word};
        end
      end
      OP_L11_MILLI, OP_L11_MICRO, OP_L11_UNIT: begin
        dec_next.exp  = word.raw_word[WORD_W-1:L11_MANT_W];
        dec_next.mant = MANT_W'($signed(word.raw_word[L11_MANT_W-1:0]));
        if (word.op == OP_L11_MILLI) begin
          dec_next.scale = SCALE_MILLI;
        end else if (word.op == OP_L11_MICRO) begin
          dec_next.scale = SCALE_MICRO;
        end else begin
          dec_next.scale = SCALE_UNIT;
        end
      end
      default: begin
        dec_next.scale = SCALE_NONE;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (take1) v1 <= word.valid;
      if (take2) v2 <= v1;
      if (take3) v3 <= v2;
    end
  end

  // Stage 1: hold the decoded beat
  always_ff @(posedge clk) begin
    if (take1 && word.valid) st1 <= dec_next;
  end

  // Stage 2: multiply the mantissa by the selected scale constant
  always_ff @(posedge clk) begin
    if (take2 && v1) begin
      st2.prod   <= st1.mant * $signed({1'b0, st1.scale});
      st2.exp    <= st1.exp;
      st2.nonlin <= st1.nonlin;
    end
  end

  plsi_exp_shift u_shift (
    .prod  (st2.prod),
    .exp   (st2.exp),
    .value (shifted)
  );

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (take3 && v2) begin
      value  <= shifted;
      nonlin <= st2.nonlin;
    end
  end

  assign result.valid           = v3;
  assign result.scaled_value    = value;
  assign result.non_linear_mode = nonlin;

  // Forced exponent only ever comes from a VOUT word
  a_nonlin_vout: assert property (@(posedge clk) disable iff (rst)
    take1 && word.valid && dec_next.nonlin |->
      (word.op == OP_VOUT_U) || (word.op == OP_VOUT_S))
    else $error("non-linear flag set on a LINEAR11 op");

  // Exponent shift never flips the sign of a nonzero result
  a_sign_kept: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (shifted[VALUE_W-1] == st2.prod[PROD_W-1]) || (shifted == '0))
    else $error("exponent shift changed the sign");

  // A forced exponent leaves the product unshifted
  a_nonlin_exp: assert property (@(posedge clk) disable iff (rst)
    v2 && st2.nonlin |-> (st2.exp == '0) && (shifted == VALUE_W'(st2.prod)))
    else $error("non-linear beat was shifted");

  // A beat moved into the next stage is not lost
  a_stage_load: assert property (@(posedge clk) disable iff (rst)
    take2 && v1 |=> v2)
    else $error("stage 2 dropped a beat");

  // A waiting result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !result.ready |=> v3 && $stable(value) && $stable(nonlin))
    else $error("stalled result overwritten");

endmodule

@@ dv/tb_pmbus_linear_to_scaled_int_unit.sv @@
// Self-checking bench for the PMBus LINEAR16 / LINEAR11 decode unit.
// Depends on plsi_pkg, plsi_word_if, plsi_result_if and the unit's RTL.
// A built-in decoder predicts each accepted word; results are checked in order.
`timescale 1ns / 1ps

module tb_pmbus_linear_to_scaled_int_unit;
  import plsi_pkg::*;

  // Op codes the unit treats as unused
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  localparam int N_RANDOM    = 1000;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYC   = 8;
  localparam int QUIET_LO    = 300;
  localparam int QUIET_HI    = 700;
  localparam int IDLE_PCT    = 19;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] raw_word;
    logic [MODE_W-1:0] mode_byte;
  } word_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      nonlin;
  } decoded_t;

  logic clk;
  logic rst;

  plsi_word_if   word_ch ();
  plsi_result_if result_ch ();

  pmbus_linear_to_scaled_int_unit dut (
    .clk    (clk),
    .rst    (rst),
    .word   (word_ch),
    .result (result_ch)
  );

  word_beat_t pending_words[$];
  decoded_t   decoded_q[$];
  int         errors;
  int         cyc;
  int         stall_cnt;

  // Clock, 20 ns period
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decode one telemetry word to its scaled value
  function automatic decoded_t decode_scaled(word_beat_t b);
    decoded_t                d;
    logic signed [EXP_W-1:0] e;
    int                      ev;
    longint                  mant;
    longint                  scale;
    longint                  prod;
    d.value  = '0;
    d.nonlin = 1'b0;
    e        = '0;
    mant     = 0;
    scale    = 0;
    case (b.op)
      OP_VOUT_U, OP_VOUT_S: begin
        // Non-linear VOUT_MODE forces a zero exponent
        if (b.mode_byte[7:5] == 3'b000) begin
          e = b.mode_byte[EXP_W-1:0];
        end else begin
          d.nonlin = 1'b1;
        end
        if (b.op == OP_VOUT_U) begin
          mant = longint'({1'b0, b.raw_word});
        end else begin
          mant = longint'($signed(b.raw_word));
        end
        scale = longint'(SCALE_MILLI);
      end
      OP_L11_MILLI, OP_L11_MICRO, OP_L11_UNIT: begin
        e    = b.raw_word[WORD_W-1:L11_MANT_W];
        mant = longint'($signed(b.raw_word[L11_MANT_W-1:0]));
        if (b.op == OP_L11_MILLI) begin
          scale = longint'(SCALE_MILLI);
        end else if (b.op == OP_L11_MICRO) begin
          scale = longint'(SCALE_MICRO);
        end else begin
          scale = longint'(SCALE_UNIT);
        end
      end
      default: begin
        return d;
      end
    endcase
    ev   = e;
    prod = mant * scale;
    // Shift left for a positive exponent, divide toward zero otherwise
    if (ev >= 0) begin
      prod = prod <<< ev;
    end else begin
      prod = prod / (longint'(1) <<< (-ev));
    end
    d.value = prod[VALUE_W-1:0];
    return d;
  endfunction

  // Random idle, with a quiet window where both sides run flat out
  function automatic bit idle_now();
    if (cyc >= QUIET_LO && cyc < QUIET_HI) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  task automatic add_word(logic [OP_W-1:0] op, logic [WORD_W-1:0] w, logic [MODE_W-1:0] m);
    word_beat_t b;
    b.op        = op;
    b.raw_word  = w;
    b.mode_byte = m;
    pending_words.push_back(b);
  endtask

  // Known values on all inputs before the first edge
  initial begin
    rst                = 1'b1;
    word_ch.valid      = 1'b0;
    word_ch.op         = '0;
    word_ch.raw_word   = '0;
    word_ch.mode_byte  = '0;
    result_ch.ready    = 1'b0;
  end

  // Word driver: hold a beat until taken, then load the next or idle
  always @(posedge clk) begin
    if (rst) begin
      word_ch.valid <= 1'b0;
    end else if (!word_ch.valid || word_ch.ready) begin
      if (pending_words.size() > 0 && !idle_now()) begin
        word_beat_t b;
        b = pending_words.pop_front();
        word_ch.op        <= b.op;
        word_ch.raw_word  <= b.raw_word;
        word_ch.mode_byte <= b.mode_byte;
        word_ch.valid     <= 1'b1;
      end else begin
        word_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !idle_now();
    end
  end

  // Predict each accepted word beat
  always @(posedge clk) begin
    if (!rst && word_ch.valid && word_ch.ready) begin
      word_beat_t b;
      b.op        = word_ch.op;
      b.raw_word  = word_ch.raw_word;
      b.mode_byte = word_ch.mode_byte;
      decoded_q.push_back(decode_scaled(b));
    end
  end

  // Check each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result beat, scaled_value %0d non_linear_mode %0b",
                 $time, result_ch.scaled_value, result_ch.non_linear_mode);
        errors++;
      end else begin
        decoded_t d;
        d = decoded_q.pop_front();
        if (result_ch.scaled_value !== d.value) begin
          $display("%0t: scaled_value expected %0d got %0d",
                   $time, d.value, result_ch.scaled_value);
          errors++;
        end
        if (result_ch.non_linear_mode !== d.nonlin) begin
          $display("%0t: non_linear_mode expected %0b got %0b",
                   $time, d.nonlin, result_ch.non_linear_mode);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (word_ch.valid && word_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] m;
    errors    = 0;
    cyc       = 0;
    stall_cnt = 0;

    // Directed: LINEAR16 exponent extremes, sign extremes, truncation
    add_word(OP_VOUT_U, 16'hffff, 8'h0f);
    add_word(OP_VOUT_U, 16'hffff, 8'h10);
    add_word(OP_VOUT_U, 16'h0000, 8'h00);
    add_word(OP_VOUT_S, 16'h8000, 8'h0f);
    add_word(OP_VOUT_S, 16'h8000, 8'h10);
    add_word(OP_VOUT_S, 16'hffff, 8'h10);
    add_word(OP_VOUT_S, 16'h7fff, 8'h00);
    add_word(OP_VOUT_S, 16'hfffd, 8'h1f);
    // Non-linear VOUT_MODE forces the exponent to zero
    add_word(OP_VOUT_U, 16'h1234, 8'hef);
    add_word(OP_VOUT_S, 16'h8001, 8'h20);
    add_word(OP_VOUT_S, 16'hffff, 8'hff);
    // LINEAR11 extremes on all three scales
    add_word(OP_L11_MILLI, 16'h7bff, 8'h00);
    add_word(OP_L11_MILLI, 16'h8400, 8'hff);
    add_word(OP_L11_MICRO, 16'h7bff, 8'h00);
    add_word(OP_L11_MICRO, 16'h7c00, 8'he0);
    add_word(OP_L11_MICRO, 16'h83ff, 8'h1f);
    add_word(OP_L11_UNIT, 16'hfffd, 8'h00);
    add_word(OP_L11_UNIT, 16'h0003, 8'h3c);
    add_word(OP_L11_UNIT, 16'h8001, 8'hff);
    add_word(OP_L11_UNIT, 16'h7c00, 8'h00);
    // Unused op codes decode to zero
    add_word(OP_RSVD_FIRST, 16'hffff, 8'hff);
    add_word(OP_RSVD_FIRST + 3'd1, 16'h7bff, 8'h0f);
    add_word(OP_RSVD_LAST, 16'h8400, 8'h20);

    // Random: mostly valid ops, mostly linear VOUT_MODE
    repeat (N_RANDOM) begin
      if ($urandom_range(0, 9) == 0) begin
        op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      end else begin
        op = OP_W'($urandom_range(OP_VOUT_U, OP_L11_UNIT));
      end
      m = MODE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 7) begin
        m[7:5] = 3'b000;
      end
      add_word(op, WORD_W'($urandom_range(0, 65535)), m);
    end

    // Hold reset, then release it
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for all beats to go in and all results to come out
    while (pending_words.size() > 0 || word_ch.valid || decoded_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/plsi_pkg.sv
rtl/plsi_word_if.sv
rtl/plsi_result_if.sv
rtl/plsi_exp_shift.sv
rtl/pmbus_linear_to_scaled_int_unit.sv
dv/tb_pmbus_linear_to_scaled_int_unit.sv
